/* sv/ulcr_pkg.sv */
package ulcr_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led_on;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    MSG_PONG,
    MSG_ERR,
    MSG_READY,
    MSG_ECHO,
    MSG_CRLF
  } msg_t;

  localparam logic [1:0] REG_LED_PERIOD    = 2'd0;
  localparam logic [1:0] REG_BANNER_PERIOD = 2'd1;

  localparam logic [15:0] LED_PERIOD_RESET    = 16'd500;
  localparam logic [15:0] BANNER_PERIOD_RESET = 16'd5000;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int PING_LEN = 4;
  localparam int ECHO_LEN = 5;

  function automatic logic [7:0] ping_char(input logic [1:0] p);
    logic [7:0] c;
    unique case (p)
      2'd0: c = "P";
      2'd1: c = "I";
      2'd2: c = "N";
      2'd3: c = "G";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] echo_char(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0: c = "E";
      3'd1: c = "C";
      3'd2: c = "H";
      3'd3: c = "O";
      3'd4: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] msg_last(input msg_t m);
    logic [2:0] n;
    unique case (m)
      MSG_PONG:  n = 3'd5;
      MSG_ERR:   n = 3'd4;
      MSG_READY: n = 3'd6;
      MSG_ECHO:  n = 3'd4;
      MSG_CRLF:  n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_byte(input msg_t m, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (m)
      MSG_PONG: begin
        case (i)
          3'd0: c = "P";
          3'd1: c = "O";
          3'd2: c = "N";
          3'd3: c = "G";
          3'd4: c = CH_CR;
          3'd5: c = CH_LF;
          default: c = 8'h00;
        endcase
      end
      MSG_ERR: begin
        case (i)
          3'd0: c = "E";
          3'd1: c = "R";
          3'd2: c = "R";
          3'd3: c = CH_CR;
          3'd4: c = CH_LF;
          default: c = 8'h00;
        endcase
      end
      MSG_READY: begin
        case (i)
          3'd0: c = "R";
          3'd1: c = "E";
          3'd2: c = "A";
          3'd3: c = "D";
          3'd4: c = "Y";
          3'd5: c = CH_CR;
          3'd6: c = CH_LF;
          default: c = 8'h00;
        endcase
      end
      MSG_ECHO: c = echo_char(i);
      MSG_CRLF: c = (i == 3'd0) ? CH_CR : CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/ulcr_ram.sv */
module ulcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/uart_line_command_responder.sv */
// Line command responder behind a UART. Each input item is either a millisecond
// tick or one received byte; every item gives one or more result items, one
// per transmitted byte, the final one flagged by last (an item with nothing to
// send gives a single result with tx_valid low). An item is taken while the
// block is idle, after which it is busy until its last result has been loaded
// into the output register, one reply byte per cycle while the output is not
// stalled; a zero byte in an echoed line ends the echo. Echoed bytes are read
// from the line RAM one per cycle while the output is not stalled, each read
// issued in the cycle the previous byte is sent. The line RAM needs no clearing
// after reset. Periods are written through the cfg port, which is always ready.
module uart_line_command_responder
  import ulcr_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(LINE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUIET,
    S_TEXT,
    S_BODY
  } state_t;

  state_t           state;
  msg_t             msg;
  logic [2:0]       msg_idx;
  logic [IDX_W-1:0] line_length;
  logic [IDX_W-1:0] body_end;
  logic [IDX_W-1:0] body_ptr;
  logic [15:0]      led_ticks;
  logic [15:0]      banner_ticks;
  logic [15:0]      led_period;
  logic [15:0]      banner_period;
  logic             led_level;
  logic             ping_match;
  logic             echo_match;
  logic             fifth_zero;

  logic             accept;
  logic             can_load;
  logic             is_lf;
  logic             is_cr;
  logic [15:0]      led_inc;
  logic [15:0]      banner_inc;
  logic [IDX_W:0]   len_inc;
  logic             room;
  logic             ping_hit;
  logic             echo_hit;
  logic [7:0]       text_byte;
  logic             text_end;
  logic [IDX_W:0]   ptr_inc;
  logic             more;
  logic             body_nonempty;

  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid || !out_stall;
  assign is_lf     = (in_item.rx_byte == CH_LF);
  assign is_cr     = (in_item.rx_byte == CH_CR);

  assign led_inc    = led_ticks + 16'd1;
  assign banner_inc = banner_ticks + 16'd1;
  assign len_inc    = {1'b0, line_length} + {{IDX_W{1'b0}}, 1'b1};
  assign room       = (len_inc < (IDX_W + 1)'(LINE_DEPTH));

  assign ping_hit = ping_match && ((line_length == IDX_W'(PING_LEN)) ||
                    ((line_length > IDX_W'(PING_LEN)) && fifth_zero));
  assign echo_hit = echo_match && (line_length >= IDX_W'(ECHO_LEN));

  assign text_byte     = msg_byte(msg, msg_idx);
  assign text_end      = (msg_idx == msg_last(msg));
  assign ptr_inc       = {1'b0, body_ptr} + {{IDX_W{1'b0}}, 1'b1};
  assign more          = (ptr_inc < {1'b0, body_end});
  assign body_nonempty = (IDX_W'(ECHO_LEN) < body_end);

  assign wr_en = accept && in_item.cmd && !is_lf && !is_cr && room;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(ECHO_LEN);
    if (state == S_TEXT && can_load && text_end && msg == MSG_ECHO) begin
      rd_en = 1'b1;
    end else if (state == S_BODY && can_load && rd_data != 8'h00 && more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_inc[IDX_W-1:0];
    end
  end

  ulcr_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(line_length),
    .wr_data(in_item.rx_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      line_length   <= '0;
      led_ticks     <= '0;
      banner_ticks  <= '0;
      led_level     <= 1'b1;
      led_period    <= LED_PERIOD_RESET;
      banner_period <= BANNER_PERIOD_RESET;
      ping_match    <= 1'b0;
      echo_match    <= 1'b0;
      fifth_zero    <= 1'b0;
      msg           <= MSG_ERR;
      msg_idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LED_PERIOD:    led_period    <= cfg_data;
          REG_BANNER_PERIOD: banner_period <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            msg_idx <= '0;
            if (!in_item.cmd) begin
              if (led_inc >= led_period) begin
                led_ticks <= '0;
                led_level <= !led_level;
              end else begin
                led_ticks <= led_inc;
              end
              if (banner_inc >= banner_period) begin
                banner_ticks <= '0;
                msg          <= MSG_READY;
                state        <= S_TEXT;
              end else begin
                banner_ticks <= banner_inc;
                state        <= S_QUIET;
              end
            end else if (is_lf) begin
              body_end    <= line_length;
              line_length <= '0;
              state       <= S_TEXT;
              if (ping_hit) begin
                msg <= MSG_PONG;
              end else if (echo_hit) begin
                msg <= MSG_ECHO;
              end else begin
                msg <= MSG_ERR;
              end
            end else if (is_cr) begin
              state <= S_QUIET;
            end else if (room) begin
              line_length <= len_inc[IDX_W-1:0];
              state       <= S_QUIET;
              if (line_length == '0) begin
                ping_match <= (in_item.rx_byte == ping_char(2'd0));
                echo_match <= (in_item.rx_byte == echo_char(3'd0));
              end else begin
                if (line_length < IDX_W'(PING_LEN)) begin
                  ping_match <= ping_match &&
                                (in_item.rx_byte == ping_char(line_length[1:0]));
                end
                if (line_length < IDX_W'(ECHO_LEN)) begin
                  echo_match <= echo_match &&
                                (in_item.rx_byte == echo_char(line_length[2:0]));
                end
                if (line_length == IDX_W'(PING_LEN)) begin
                  fifth_zero <= (in_item.rx_byte == 8'h00);
                end
              end
            end else begin
              line_length <= '0;
              msg         <= MSG_ERR;
              state       <= S_TEXT;
            end
          end
        end

        S_QUIET: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_item  <= '{tx_valid: 1'b0, tx_byte: 8'h00, led_on: led_level, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        S_TEXT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_item  <= '{tx_valid: 1'b1, tx_byte: text_byte, led_on: led_level,
                           last: text_end && (msg != MSG_ECHO)};
            if (text_end) begin
              msg_idx <= '0;
              if (msg == MSG_ECHO) begin
                body_ptr <= IDX_W'(ECHO_LEN);
                if (body_nonempty) begin
                  state <= S_BODY;
                end else begin
                  msg <= MSG_CRLF;
                end
              end else begin
                state <= S_IDLE;
              end
            end else begin
              msg_idx <= msg_idx + 3'd1;
            end
          end
        end

        S_BODY: begin
          if (rd_data == 8'h00) begin
            msg     <= MSG_CRLF;
            msg_idx <= '0;
            state   <= S_TEXT;
          end else if (can_load) begin
            out_valid <= 1'b1;
            out_item  <= '{tx_valid: 1'b1, tx_byte: rd_data, led_on: led_level, last: 1'b0};
            body_ptr  <= ptr_inc[IDX_W-1:0];
            if (!more) begin
              msg     <= MSG_CRLF;
              msg_idx <= '0;
              state   <= S_TEXT;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item left no pending result");

  a_silent_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.tx_valid || out_item.last))
    else $error("empty result not marked last");

  a_lf_clears_line: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.cmd && (is_lf || (!is_cr && !room))) |=> (line_length == '0))
    else $error("line not cleared after answer or overflow");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BODY) |-> (body_ptr < body_end))
    else $error("echo pointer ran past the line");

endmodule
